// ----- rtl/apcl_pkg.sv -----
// Shared types, constants and helpers for the alarm panel code lock.
// No dependencies; used by every other file in rtl/.
`default_nettype none

package apcl_pkg;

    localparam int MAX_CODE_LEN = 10;
    localparam int SENSOR_COUNT = 4;

    localparam int IDX_W      = $clog2(MAX_CODE_LEN);
    localparam int PTR_W      = $clog2(MAX_CODE_LEN + 1);
    localparam int KEY_W      = 8;
    localparam int READ_W     = 8;
    localparam int TIMEOUT_W  = 16;
    localparam int MINLEN_W   = 4;
    localparam int COUNT_W    = 4;
    localparam int CMP_W      = (PTR_W > MINLEN_W) ? PTR_W : MINLEN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    localparam int RESET_CODE_LEN = 4;

    localparam logic [READ_W-1:0] SENSOR_MASK =
        READ_W'((64'd1 << (2 * SENSOR_COUNT)) - 64'd1);

    localparam logic [TIMEOUT_W-1:0] RST_ENTRY_TIMEOUT = 16'd4000;
    localparam logic [MINLEN_W-1:0]  RST_MIN_CODE_LEN  = 4'd3;
    localparam logic [KEY_W-1:0]     RST_ARM_KEY       = 8'd13;
    localparam logic [KEY_W-1:0]     RST_NEW_CODE_KEY  = 8'd14;
    localparam logic [KEY_W-1:0]     RST_LEARN_KEY     = 8'd15;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ARMED   = 2'd1,
        MODE_ALARM   = 2'd2,
        MODE_NEWCODE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_ARMED     = 3'd1,
        EV_REFUSED   = 3'd2,
        EV_DISARMED  = 3'd3,
        EV_TIMEOUT   = 3'd4,
        EV_SAVED     = 3'd5,
        EV_SHORT     = 3'd6,
        EV_LEARNED   = 3'd7
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_TIMEOUT = 3'd0,
        CFG_MIN_CODE_LEN  = 3'd1,
        CFG_ARM_KEY       = 3'd2,
        CFG_NEW_CODE_KEY  = 3'd3,
        CFG_LEARN_KEY     = 3'd4
    } cfg_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_COPY,
        OP_CMP
    } op_t;

    typedef struct packed {
        logic              cover_open;
        logic [READ_W-1:0] sensor_reading;
        logic [KEY_W-1:0]  key;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] entered_count;
        logic               siren_on;
        event_t             event_res;
        mode_t              panel_mode;
    } result_t;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             ent_we;
        logic             code_we;
        logic [IDX_W-1:0] wr_addr;
        logic [KEY_W-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] ent_data;
        logic [KEY_W-1:0] code_data;
    } mem_rsp_t;

    function automatic logic [KEY_W-1:0] code_reset_value(input logic [IDX_W-1:0] idx);
        return (idx < IDX_W'(RESET_CODE_LEN)) ? KEY_W'(1) : '0;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/apcl_store.sv -----
// Entry buffer and stored code memories, with registered reads.
// Depends on apcl_pkg; stored code entries read as the factory code until written.
`default_nettype none

module apcl_store (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire apcl_pkg::mem_req_t  req,
    output apcl_pkg::mem_rsp_t       rsp
);

    logic [apcl_pkg::KEY_W-1:0] ent_mem  [apcl_pkg::MAX_CODE_LEN];
    logic [apcl_pkg::KEY_W-1:0] code_mem [apcl_pkg::MAX_CODE_LEN];

    logic [apcl_pkg::MAX_CODE_LEN-1:0] code_valid_reg, code_valid_next;
    logic [apcl_pkg::KEY_W-1:0]        ent_q_reg, code_q_reg;

    always_comb begin
        code_valid_next = code_valid_reg;
        if (req.code_we) begin
            code_valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_valid_reg <= '0;
        end else begin
            code_valid_reg <= code_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.ent_we) begin
            ent_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.code_we) begin
            code_mem[req.wr_addr] <= req.wr_data;
        end
        ent_q_reg  <= ent_mem[req.rd_addr];
        code_q_reg <= code_valid_reg[req.rd_addr] ? code_mem[req.rd_addr]
                                                  : apcl_pkg::code_reset_value(req.rd_addr);
    end

    assign rsp.ent_data  = ent_q_reg;
    assign rsp.code_data = code_q_reg;

endmodule

`default_nettype wire

// ----- rtl/apcl_ctrl.sv -----
// Sequencer and scalar state of the panel: mode, pointers, timeout, config.
// Depends on apcl_pkg; drives the memories in apcl_store.
`default_nettype none

module apcl_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               s_cmd,
    input  wire apcl_pkg::item_t    s_item,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output apcl_pkg::result_t       m_result,
    input  wire apcl_pkg::cfg_wr_t  cfg,
    output apcl_pkg::mem_req_t      mem_req,
    input  wire apcl_pkg::mem_rsp_t mem_rsp
);

    typedef struct packed {
        apcl_pkg::mode_t                   mode;
        apcl_pkg::event_t                  ev;
        logic [apcl_pkg::READ_W-1:0]       sref;
        logic [apcl_pkg::PTR_W-1:0]        up;
        logic [apcl_pkg::PTR_W-1:0]        np;
        logic [apcl_pkg::PTR_W-1:0]        len;
        logic [apcl_pkg::TIMEOUT_W-1:0]    tc;
        apcl_pkg::op_t                     op;
        logic                              ent_we;
        logic [apcl_pkg::IDX_W-1:0]        wr_addr;
    } exec_t;

    apcl_pkg::state_t state_reg, state_next;

    logic [apcl_pkg::TIMEOUT_W-1:0] timeout_cfg_reg, timeout_cfg_next;
    logic [apcl_pkg::MINLEN_W-1:0]  min_len_reg, min_len_next;
    logic [apcl_pkg::KEY_W-1:0]     arm_key_reg, arm_key_next;
    logic [apcl_pkg::KEY_W-1:0]     new_key_reg, new_key_next;
    logic [apcl_pkg::KEY_W-1:0]     learn_key_reg, learn_key_next;

    apcl_pkg::mode_t                mode_reg, mode_next;
    logic [apcl_pkg::PTR_W-1:0]     up_reg, up_next;
    logic [apcl_pkg::PTR_W-1:0]     np_reg, np_next;
    logic [apcl_pkg::PTR_W-1:0]     len_reg, len_next;
    logic [apcl_pkg::TIMEOUT_W-1:0] tc_reg, tc_next;
    logic [apcl_pkg::READ_W-1:0]    sref_reg, sref_next;
    logic                           out_valid_reg, out_valid_next;

    logic                           cmd_reg, cmd_next;
    apcl_pkg::item_t                item_reg, item_next;
    apcl_pkg::event_t               ev_reg, ev_next;
    logic [apcl_pkg::PTR_W-1:0]     idx_reg, idx_next;
    apcl_pkg::result_t              out_reg, out_next;

    exec_t                          ex;
    logic [apcl_pkg::PTR_W-1:0]     idx_inc;
    logic                           copy_last, cmp_last, cmp_equal, out_free;

    assign idx_inc   = idx_reg + 1'b1;
    assign copy_last = (idx_inc == len_reg);
    assign cmp_last  = (idx_inc == up_reg);
    assign cmp_equal = (mem_rsp.ent_data == mem_rsp.code_data);
    assign out_free  = !out_valid_reg || m_tready;

    // scan and tick handling on the captured transaction
    always_comb begin
        logic [apcl_pkg::KEY_W-1:0] k;
        logic                       match;
        ex.mode    = mode_reg;
        ex.ev      = apcl_pkg::EV_NONE;
        ex.sref    = sref_reg;
        ex.up      = up_reg;
        ex.np      = np_reg;
        ex.len     = len_reg;
        ex.tc      = tc_reg;
        ex.op      = apcl_pkg::OP_NONE;
        ex.ent_we  = 1'b0;
        ex.wr_addr = '0;
        k          = item_reg.key;
        match      = ((item_reg.sensor_reading ^ sref_reg) & apcl_pkg::SENSOR_MASK) == '0;
        if (cmd_reg == apcl_pkg::CMD_TICK) begin
            if (tc_reg != '0) begin
                ex.tc = tc_reg - 1'b1;
                if (ex.tc == '0) begin
                    ex.up = '0;
                    ex.ev = apcl_pkg::EV_TIMEOUT;
                end
            end
        end else begin
            if (ex.mode == apcl_pkg::MODE_IDLE) begin
                if (k != '0) begin
                    if (k == arm_key_reg) begin
                        if (match) begin
                            ex.mode = apcl_pkg::MODE_ARMED;
                            ex.ev   = apcl_pkg::EV_ARMED;
                        end else begin
                            ex.ev = apcl_pkg::EV_REFUSED;
                        end
                    end else if (k == new_key_reg) begin
                        ex.mode = apcl_pkg::MODE_NEWCODE;
                    end else if (k == learn_key_reg) begin
                        ex.sref = item_reg.sensor_reading & apcl_pkg::SENSOR_MASK;
                        ex.ev   = apcl_pkg::EV_LEARNED;
                    end
                end
                k = '0;
            end
            if (ex.mode == apcl_pkg::MODE_NEWCODE) begin
                if (np_reg >= apcl_pkg::PTR_W'(apcl_pkg::MAX_CODE_LEN)
                    || (k != '0 && k == new_key_reg)) begin
                    if (apcl_pkg::CMP_W'(np_reg) < apcl_pkg::CMP_W'(min_len_reg)) begin
                        ex.ev = apcl_pkg::EV_SHORT;
                    end else begin
                        ex.len = np_reg;
                        ex.ev  = apcl_pkg::EV_SAVED;
                        if (np_reg != '0) begin
                            ex.op = apcl_pkg::OP_COPY;
                        end
                    end
                    ex.np   = '0;
                    ex.mode = apcl_pkg::MODE_IDLE;
                end else if (k != '0) begin
                    ex.ent_we  = 1'b1;
                    ex.wr_addr = np_reg[apcl_pkg::IDX_W-1:0];
                    ex.np      = np_reg + 1'b1;
                end
            end
            if (ex.mode == apcl_pkg::MODE_ARMED && item_reg.cover_open) begin
                ex.mode = apcl_pkg::MODE_ALARM;
            end
            if (ex.mode == apcl_pkg::MODE_ARMED || ex.mode == apcl_pkg::MODE_ALARM) begin
                if (!match) begin
                    ex.mode = apcl_pkg::MODE_ALARM;
                end
                if (k != '0) begin
                    ex.tc = timeout_cfg_reg;
                    if (up_reg < apcl_pkg::PTR_W'(apcl_pkg::MAX_CODE_LEN)) begin
                        ex.ent_we  = 1'b1;
                        ex.wr_addr = up_reg[apcl_pkg::IDX_W-1:0];
                        ex.up      = up_reg + 1'b1;
                        if (ex.up == len_reg) begin
                            ex.op = apcl_pkg::OP_CMP;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            apcl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = apcl_pkg::ST_EXEC;
                end
            end
            apcl_pkg::ST_EXEC: begin
                case (ex.op)
                    apcl_pkg::OP_COPY: state_next = apcl_pkg::ST_COPY_RD;
                    apcl_pkg::OP_CMP:  state_next = apcl_pkg::ST_CMP_RD;
                    default:           state_next = apcl_pkg::ST_DONE;
                endcase
            end
            apcl_pkg::ST_COPY_RD: state_next = apcl_pkg::ST_COPY_WR;
            apcl_pkg::ST_COPY_WR: begin
                state_next = copy_last ? apcl_pkg::ST_DONE : apcl_pkg::ST_COPY_RD;
            end
            apcl_pkg::ST_CMP_RD: state_next = apcl_pkg::ST_CMP_CHK;
            apcl_pkg::ST_CMP_CHK: begin
                state_next = (!cmp_equal || cmp_last) ? apcl_pkg::ST_DONE
                                                      : apcl_pkg::ST_CMP_RD;
            end
            apcl_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = apcl_pkg::ST_IDLE;
                end
            end
            default: state_next = apcl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        timeout_cfg_next = timeout_cfg_reg;
        min_len_next     = min_len_reg;
        arm_key_next     = arm_key_reg;
        new_key_next     = new_key_reg;
        learn_key_next   = learn_key_reg;
        mode_next        = mode_reg;
        up_next          = up_reg;
        np_next          = np_reg;
        len_next         = len_reg;
        tc_next          = tc_reg;
        sref_next        = sref_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        cmd_next         = cmd_reg;
        item_next        = item_reg;
        ev_next          = ev_reg;
        idx_next         = idx_reg;
        out_next         = out_reg;
        mem_req.rd_addr  = idx_reg[apcl_pkg::IDX_W-1:0];
        mem_req.ent_we   = 1'b0;
        mem_req.code_we  = 1'b0;
        mem_req.wr_addr  = '0;
        mem_req.wr_data  = item_reg.key;

        if (cfg.wr_en) begin
            case (cfg.index)
                apcl_pkg::CFG_ENTRY_TIMEOUT: timeout_cfg_next = cfg.data;
                apcl_pkg::CFG_MIN_CODE_LEN:  min_len_next = cfg.data[apcl_pkg::MINLEN_W-1:0];
                apcl_pkg::CFG_ARM_KEY:       arm_key_next = cfg.data[apcl_pkg::KEY_W-1:0];
                apcl_pkg::CFG_NEW_CODE_KEY:  new_key_next = cfg.data[apcl_pkg::KEY_W-1:0];
                apcl_pkg::CFG_LEARN_KEY:     learn_key_next = cfg.data[apcl_pkg::KEY_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            apcl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = s_cmd;
                    item_next = s_item;
                end
            end
            apcl_pkg::ST_EXEC: begin
                mode_next       = ex.mode;
                ev_next         = ex.ev;
                sref_next       = ex.sref;
                up_next         = ex.up;
                np_next         = ex.np;
                len_next        = ex.len;
                tc_next         = ex.tc;
                idx_next        = '0;
                mem_req.ent_we  = ex.ent_we;
                mem_req.wr_addr = ex.wr_addr;
            end
            apcl_pkg::ST_COPY_WR: begin
                mem_req.code_we = 1'b1;
                mem_req.wr_addr = idx_reg[apcl_pkg::IDX_W-1:0];
                mem_req.wr_data = mem_rsp.ent_data;
                idx_next        = idx_inc;
            end
            apcl_pkg::ST_CMP_CHK: begin
                if (cmp_equal) begin
                    if (cmp_last) begin
                        mode_next = apcl_pkg::MODE_IDLE;
                        up_next   = '0;
                        tc_next   = '0;
                        ev_next   = apcl_pkg::EV_DISARMED;
                    end else begin
                        idx_next = idx_inc;
                    end
                end
            end
            apcl_pkg::ST_DONE: begin
                if (out_free) begin
                    out_valid_next         = 1'b1;
                    out_next.panel_mode    = mode_reg;
                    out_next.event_res     = ev_reg;
                    out_next.siren_on      = (mode_reg == apcl_pkg::MODE_ALARM);
                    out_next.entered_count = apcl_pkg::COUNT_W'(up_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= apcl_pkg::ST_IDLE;
            timeout_cfg_reg <= apcl_pkg::RST_ENTRY_TIMEOUT;
            min_len_reg     <= apcl_pkg::RST_MIN_CODE_LEN;
            arm_key_reg     <= apcl_pkg::RST_ARM_KEY;
            new_key_reg     <= apcl_pkg::RST_NEW_CODE_KEY;
            learn_key_reg   <= apcl_pkg::RST_LEARN_KEY;
            mode_reg        <= apcl_pkg::MODE_ARMED;
            up_reg          <= '0;
            np_reg          <= '0;
            len_reg         <= apcl_pkg::PTR_W'(apcl_pkg::RESET_CODE_LEN);
            tc_reg          <= '0;
            sref_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            timeout_cfg_reg <= timeout_cfg_next;
            min_len_reg     <= min_len_next;
            arm_key_reg     <= arm_key_next;
            new_key_reg     <= new_key_next;
            learn_key_reg   <= learn_key_next;
            mode_reg        <= mode_next;
            up_reg          <= up_next;
            np_reg          <= np_next;
            len_reg         <= len_next;
            tc_reg          <= tc_next;
            sref_reg        <= sref_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        item_reg <= item_next;
        ev_reg   <= ev_next;
        idx_reg  <= idx_next;
        out_reg  <= out_next;
    end

    assign s_tready = (state_reg == apcl_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

endmodule

`default_nettype wire

// ----- rtl/alarm_panel_code_lock_core.sv -----
// Alarm panel code lock: keypad lock and alarm controller, one result per transaction.
// Input stream: s_tuser selects a timer tick (0) or a keypad scan (1); s_tdata carries
// the key, the sensor loop readings and the cover switch. Output stream: one result
// transaction per input with mode, event, siren and the unlock entry count.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one register per clock, no read-back.
// A transaction runs through IDLE, EXEC and DONE, and DONE registers its result;
// a scan that saves a new code adds COPY_RD and COPY_WR per symbol (copy through the
// entry memory read port); a scan that completes an unlock entry adds CMP_RD and
// CMP_CHK per symbol up to a mismatch (serial compare); one transaction in flight.
// A new input transaction is taken while the previous result waits in the output
// register; if the receiver stalls, the next result holds the sequencer until the
// output register frees, and s_tready stays low meanwhile.
// Reset (aresetn low, synchronous) leaves the panel armed with the factory code of
// four ones, empty entry, zero timer, zero sensor reference and default registers.
// No clearing pass: the stored code reads as the factory code until rewritten.
// Depends on apcl_pkg, apcl_ctrl, apcl_store.
`default_nettype none

module alarm_panel_code_lock_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // key[7:0], sensor_reading[15:8], cover_open[16], zero fill
    input  wire logic [apcl_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd[0]
    input  wire logic [0:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // panel_mode[1:0], event_res[4:2], siren_on[5], entered_count[9:6], zero fill
    output logic [apcl_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [apcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [apcl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    apcl_pkg::item_t    s_item;
    apcl_pkg::result_t  m_result;
    apcl_pkg::cfg_wr_t  cfg;
    apcl_pkg::mem_req_t mem_req;
    apcl_pkg::mem_rsp_t mem_rsp;

    assign s_item    = s_tdata[$bits(apcl_pkg::item_t)-1:0];
    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;
    assign m_tdata   = apcl_pkg::M_TDATA_W'(m_result);

    apcl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser[0]),
        .s_item   (s_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result),
        .cfg      (cfg),
        .mem_req  (mem_req),
        .mem_rsp  (mem_rsp)
    );

    apcl_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rsp     (mem_rsp)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_result.entered_count <= apcl_pkg::COUNT_W'(apcl_pkg::MAX_CODE_LEN)))
        else $error("entered_count beyond code buffer depth");

    a_siren_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_result.siren_on == (m_result.panel_mode == apcl_pkg::MODE_ALARM)))
        else $error("siren_on disagrees with panel_mode");

    a_disarm_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_result.event_res == apcl_pkg::EV_DISARMED)
        |-> (m_result.panel_mode == apcl_pkg::MODE_IDLE && m_result.entered_count == '0))
        else $error("disarm left mode or entry count set");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken while one is in work");
`endif

endmodule

`default_nettype wire

// ----- test/alarm_panel_code_lock_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for alarm_panel_code_lock_core: directed and random scans and ticks,
// predicted per transaction by a panel model in a scoreboard class and checked in order.
// Depends on apcl_pkg and the core RTL only.

import apcl_pkg::*;

class panel_checker;
    logic [15:0] entry_timeout;
    logic [3:0]  min_len;
    logic [7:0]  arm_key;
    logic [7:0]  newcode_key;
    logic [7:0]  learn_key;

    mode_t       mode;
    logic [7:0]  entry_buf [MAX_CODE_LEN];
    logic [7:0]  stored_code [MAX_CODE_LEN];
    int unsigned unlock_ptr;
    int unsigned newcode_ptr;
    int unsigned stored_len;
    logic [15:0] timeout_count;
    logic [7:0]  sensor_ref;

    result_t     expected_results [$];
    int unsigned mismatches;

    function new();
        int i;
        entry_timeout = RST_ENTRY_TIMEOUT;
        min_len       = RST_MIN_CODE_LEN;
        arm_key       = RST_ARM_KEY;
        newcode_key   = RST_NEW_CODE_KEY;
        learn_key     = RST_LEARN_KEY;
        mode          = MODE_ARMED;
        for (i = 0; i < MAX_CODE_LEN; i++) begin
            entry_buf[i]   = 8'h00;
            stored_code[i] = (i < 4) ? 8'h01 : 8'h00;
        end
        unlock_ptr    = 0;
        newcode_ptr   = 0;
        stored_len    = 4;
        timeout_count = '0;
        sensor_ref    = '0;
        mismatches    = 0;
    endfunction

    function void set_register(cfg_sel_t sel, logic [15:0] value);
        case (sel)
            CFG_ENTRY_TIMEOUT: entry_timeout = value;
            CFG_MIN_CODE_LEN:  min_len = value[3:0];
            CFG_ARM_KEY:       arm_key = value[7:0];
            CFG_NEW_CODE_KEY:  newcode_key = value[7:0];
            CFG_LEARN_KEY:     learn_key = value[7:0];
            default: ;
        endcase
    endfunction

    function bit sensors_ok(logic [7:0] reading);
        return ((reading ^ sensor_ref) & SENSOR_MASK) == 8'h00;
    endfunction

    function bit entry_can_match();
        int i;
        if (unlock_ptr >= stored_len)
            return 0;
        for (i = 0; i < unlock_ptr; i++)
            if (entry_buf[i] != stored_code[i])
                return 0;
        return 1;
    endfunction

    function event_t newcode_step(logic [7:0] key);
        event_t ev;
        int i;
        if (newcode_ptr >= MAX_CODE_LEN || (key != 8'h00 && key == newcode_key)) begin
            if (newcode_ptr < min_len) begin
                ev = EV_SHORT;
            end else begin
                for (i = 0; i < newcode_ptr; i++)
                    stored_code[i] = entry_buf[i];
                stored_len = newcode_ptr;
                ev = EV_SAVED;
            end
            newcode_ptr = 0;
            mode = MODE_IDLE;
            return ev;
        end
        if (key != 8'h00) begin
            entry_buf[newcode_ptr] = key;
            newcode_ptr++;
        end
        return EV_NONE;
    endfunction

    function event_t unlock_step(logic [7:0] key);
        bit same;
        int i;
        if (key == 8'h00)
            return EV_NONE;
        if (unlock_ptr < MAX_CODE_LEN) begin
            entry_buf[unlock_ptr] = key;
            unlock_ptr++;
            if (unlock_ptr == stored_len) begin
                same = 1;
                for (i = 0; i < unlock_ptr; i++)
                    if (stored_code[i] != entry_buf[i])
                        same = 0;
                if (same) begin
                    mode = MODE_IDLE;
                    unlock_ptr = 0;
                    timeout_count = '0;
                    return EV_DISARMED;
                end
            end
        end
        timeout_count = entry_timeout;
        return EV_NONE;
    endfunction

    function void note_item(logic cmd, logic [7:0] key_in, logic [7:0] reading, logic cover_sw);
        logic [7:0] key;
        event_t     ev;
        event_t     step_ev;
        result_t    res;
        key = key_in;
        ev  = EV_NONE;
        if (cmd == CMD_TICK) begin
            if (timeout_count != 0) begin
                timeout_count--;
                if (timeout_count == 0) begin
                    unlock_ptr = 0;
                    ev = EV_TIMEOUT;
                end
            end
        end else begin
            if (mode == MODE_IDLE) begin
                if (key != 8'h00) begin
                    if (key == arm_key) begin
                        if (sensors_ok(reading)) begin
                            mode = MODE_ARMED;
                            ev = EV_ARMED;
                        end else begin
                            ev = EV_REFUSED;
                        end
                    end else if (key == newcode_key) begin
                        mode = MODE_NEWCODE;
                    end else if (key == learn_key) begin
                        sensor_ref = reading & SENSOR_MASK;
                        ev = EV_LEARNED;
                    end
                end
                key = 8'h00;
            end
            if (mode == MODE_NEWCODE) begin
                step_ev = newcode_step(key);
                if (step_ev != EV_NONE)
                    ev = step_ev;
            end
            if (mode == MODE_ARMED && cover_sw)
                mode = MODE_ALARM;
            if (mode == MODE_ARMED || mode == MODE_ALARM) begin
                if (!sensors_ok(reading))
                    mode = MODE_ALARM;
                step_ev = unlock_step(key);
                if (step_ev != EV_NONE)
                    ev = step_ev;
            end
        end
        res.panel_mode    = mode;
        res.event_res     = ev;
        res.siren_on      = (mode == MODE_ALARM);
        res.entered_count = 4'(unlock_ptr);
        expected_results.push_back(res);
    endfunction

    function void check_result(logic [15:0] word);
        result_t got;
        result_t want;
        got = result_t'(word[9:0]);
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transaction: data %h", word);
            return;
        end
        want = expected_results.pop_front();
        if (got.panel_mode !== want.panel_mode || got.event_res !== want.event_res ||
            got.siren_on !== want.siren_on || got.entered_count !== want.entered_count) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: mode %0d/%0d event %0d/%0d siren %0d/%0d count %0d/%0d (exp/got)",
                         want.panel_mode, got.panel_mode, want.event_res, got.event_res,
                         want.siren_on, got.siren_on, want.entered_count, got.entered_count);
        end
    endfunction
endclass

module alarm_panel_code_lock_core_test;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    cfg_sel_t    cfg_index = CFG_ENTRY_TIMEOUT;
    logic [15:0] cfg_data = '0;

    logic [9:0]  ready_phase = '0;
    int          burst_left = 0;
    panel_checker panel;

    alarm_panel_code_lock_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        ready_phase <= ready_phase + 10'd1;
        case (ready_phase[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= (ready_phase[1:0] != 2'd3);
            2'd2:    m_tready <= ready_phase[3];
            default: m_tready <= ($urandom_range(0, 2) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            panel.check_result(m_tdata);
    end

    task automatic push_item(input logic cmd, input logic [7:0] key,
                             input logic [7:0] reading, input logic cover_sw);
        int gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, cover_sw, reading, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        panel.note_item(cmd, key, reading, cover_sw);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (panel.expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_sel_t sel, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge aclk);
        panel.set_register(sel, value);
    endtask

    task automatic set_panel(input logic [15:0] timeout, input logic [3:0] min_len,
                             input logic [7:0] arm, input logic [7:0] newcode,
                             input logic [7:0] learn);
        write_reg(CFG_ENTRY_TIMEOUT, timeout);
        write_reg(CFG_MIN_CODE_LEN, {12'b0, min_len});
        write_reg(CFG_ARM_KEY, {8'b0, arm});
        write_reg(CFG_NEW_CODE_KEY, {8'b0, newcode});
        write_reg(CFG_LEARN_KEY, {8'b0, learn});
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // bias toward well-formed arming, code entry and unlocking from the current mode
    task automatic random_item();
        logic       cmd;
        logic       cover_sw;
        logic [7:0] key;
        logic [7:0] reading;
        int         pick;
        bit         hopeless;
        hopeless = (panel.mode == MODE_ARMED || panel.mode == MODE_ALARM) &&
                   !panel.entry_can_match();
        pick = $urandom_range(0, 99);
        cmd = (pick < (hopeless ? 60 : 20)) ? CMD_TICK : CMD_SCAN;
        reading = ($urandom_range(0, 6) == 0) ? 8'($urandom) : panel.sensor_ref;
        cover_sw = ($urandom_range(0, 24) == 0);
        pick = $urandom_range(0, 99);
        case (panel.mode)
            MODE_IDLE:
                key = (pick < 30) ? panel.arm_key :
                      (pick < 50) ? panel.newcode_key :
                      (pick < 65) ? panel.learn_key :
                      (pick < 80) ? 8'h00 : 8'($urandom);
            MODE_NEWCODE:
                key = (pick < 60) ? 8'($urandom_range(1, 6)) :
                      (pick < 72) ? panel.newcode_key :
                      (pick < 85) ? 8'h00 : 8'($urandom);
            default:
                key = (pick < 70 && !hopeless) ? panel.stored_code[panel.unlock_ptr] :
                      (pick < 80) ? 8'h00 : 8'($urandom);
        endcase
        push_item(cmd, key, reading, cover_sw);
    endtask

    initial begin
        int phase;
        int phase_len;
        logic [7:0] symbols [10];
        panel = new();
        symbols = '{8'hFF, 8'h80, 8'h7F, 8'h01, 8'h55, 8'hAA, 8'hFE, 8'h02, 8'h10, RST_ARM_KEY};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_item(CMD_TICK, 8'h00, 8'h00, 1'b0);
        repeat (4) push_item(CMD_SCAN, 8'h01, 8'h00, 1'b0);
        push_item(CMD_SCAN, RST_LEARN_KEY, 8'hFF, 1'b0);
        push_item(CMD_SCAN, RST_ARM_KEY, 8'h00, 1'b0);
        push_item(CMD_SCAN, RST_NEW_CODE_KEY, 8'hFF, 1'b1);
        push_item(CMD_SCAN, 8'hAA, 8'h00, 1'b0);
        push_item(CMD_SCAN, RST_NEW_CODE_KEY, 8'hFF, 1'b0);
        push_item(CMD_SCAN, RST_NEW_CODE_KEY, 8'hFF, 1'b0);
        foreach (symbols[i]) push_item(CMD_SCAN, symbols[i], 8'hFF, 1'b0);
        // full buffer: finish on a scan without a key
        push_item(CMD_SCAN, 8'h00, 8'hFF, 1'b0);
        push_item(CMD_SCAN, RST_ARM_KEY, 8'hFF, 1'b1);

        for (phase = 0; phase < 7; phase++) begin
            drain();
            phase_len = 350;
            case (phase)
                0: set_panel(16'd6, 4'd3, 8'd13, 8'd14, 8'd15);
                1: set_panel(16'd1, 4'd1, 8'd1, 8'd2, 8'd3);
                2: begin
                    set_panel(16'hFFFF, 4'd10, 8'd255, 8'd254, 8'd253);
                    phase_len = 150;
                end
                3: begin
                    // countdown disabled: partial entries stay
                    set_panel(16'd0, 4'd3, 8'd13, 8'd14, 8'd15);
                    phase_len = 100;
                end
                4: set_panel(16'd4, 4'd2, 8'd9, 8'd9, 8'd9);
                5: set_panel(16'd3, 4'd4, 8'd20, 8'd21, 8'd21);
                default: set_panel(16'($urandom_range(2, 40)), 4'($urandom_range(1, 10)),
                                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                                   8'($urandom_range(1, 255)));
            endcase
            repeat (phase_len) random_item();
        end

        drain();
        repeat (25) @(posedge aclk);
        if (panel.mismatches == 0 && panel.expected_results.size() == 0) begin
            $display("alarm_panel_code_lock_core_test: clean");
        end else begin
            $display("alarm_panel_code_lock_core_test: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("alarm_panel_code_lock_core_test: errors");
        $finish;
    end

endmodule
